>>> hw/rtl/srt_pkg.sv
// Shared types, constants and codes for the selective-repeat retransmit tracker.
// No dependencies; the design modules refer to this package by scoped names, the testbench imports it.
`timescale 1ns / 1ps

package srt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ACK_WINDOW  = 5;
	// the mask field is five bits wide, so the window never reaches past it
	localparam int ACK_SPAN    = (ACK_WINDOW < 5) ? ACK_WINDOW : 5;
	localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;

	typedef logic [31:0]       id_t;
	typedef logic [15:0]       age_t;
	typedef logic [3:0]        retry_t;
	typedef logic [2:0]        clr_t;
	typedef logic [4:0]        outst_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam age_t AGE_MAX = 16'hFFFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SESSION      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_TMO     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_TMO      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTEND_AFTER = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT  = 3'd4;

	localparam id_t    RST_SESSION      = 32'd0;
	localparam age_t   RST_BASE_TMO     = 16'd200;
	localparam age_t   RST_EXT_TMO      = 16'd500;
	localparam retry_t RST_EXTEND_AFTER = 4'd3;
	localparam retry_t RST_RETRY_LIMIT  = 4'd5;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SEND = 2'd1,
		CMD_ACK  = 2'd2,
		CMD_NOP  = 2'd3
	} cmd_e;

	typedef enum logic [2:0] {
		KIND_SENT      = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_ACKED     = 3'd2,
		KIND_BAD_SESS  = 3'd3,
		KIND_RETX      = 3'd4,
		KIND_DROP      = 3'd5,
		KIND_IDLE      = 3'd6
	} kind_e;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_e;

	typedef struct packed {
		id_t    session_id;
		age_t   base_timeout;
		age_t   extended_timeout;
		retry_t extend_after_retries;
		retry_t retry_limit;
	} cfg_t;

	typedef struct packed {
		logic   id_eq;
		logic   ack_hit;
		logic   expire;
		logic   drop;
		age_t   age_next;
		retry_t retries_next;
	} alu_res_t;

	typedef struct packed {
		kind_e  kind;
		id_t    result_id;
		retry_t attempt;
		clr_t   cleared_count;
		outst_t outstanding;
		logic   last;
	} result_t;

endpackage

>>> hw/rtl/srt_in_if.sv
// Command channel of the retransmit tracker: valid/ready plus one command beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface srt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] packet_id;
	logic [31:0] ack_session;
	logic [31:0] ack_first_id;
	logic [4:0]  ack_mask;

	modport source (output valid, cmd, packet_id, ack_session, ack_first_id, ack_mask,
		input ready);
	modport sink (input valid, cmd, packet_id, ack_session, ack_first_id, ack_mask,
		output ready);
endinterface

>>> hw/rtl/srt_out_if.sv
// Result channel of the retransmit tracker: valid/ready plus one result beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface srt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [31:0] result_id;
	logic [3:0]  attempt;
	logic [2:0]  cleared_count;
	logic [4:0]  outstanding;
	logic        last;

	modport source (output valid, kind, result_id, attempt, cleared_count, outstanding,
		last, input ready);
	modport sink (input valid, kind, result_id, attempt, cleared_count, outstanding,
		last, output ready);
endinterface

>>> hw/rtl/srt_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.
`timescale 1ns / 1ps

interface srt_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/selective_ack_retransmit_tracker.sv
// Sender-side selective-repeat tracker: a sequencer walks the 16-entry table one
// slot per cycle through the shared entry unit. Send, matching ack and tick go
// from accept through a scan of all slots to finish; a wrong-session ack or
// unused command skips the scan. A full output register can stall a tick scan.
// One item at a time. Reset empties the table and loads register defaults.
`timescale 1ns / 1ps

module selective_ack_retransmit_tracker (
	input  logic      clk,
	input  logic      arst_n,
	srt_in_if.sink    req,
	srt_out_if.source res,
	srt_cfg_if.sink   cfg
);

	srt_pkg::cfg_t     regs;
	srt_pkg::alu_res_t alu;

	srt_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// entry table
	logic            valid_q   [srt_pkg::TABLE_DEPTH];
	srt_pkg::id_t    id_q      [srt_pkg::TABLE_DEPTH];
	srt_pkg::retry_t retries_q [srt_pkg::TABLE_DEPTH];
	srt_pkg::age_t   age_q     [srt_pkg::TABLE_DEPTH];

	srt_pkg::state_e state_q;
	srt_pkg::cmd_e   cmd_q;
	srt_pkg::id_t    key_q;
	logic [4:0]      mask_q;
	logic            sess_ok_q;
	srt_pkg::slot_t  slot_q;
	srt_pkg::cnt_t   cnt_q;
	logic            match_found_q, free_found_q;
	srt_pkg::slot_t  match_slot_q, free_slot_q;
	srt_pkg::clr_t   cleared_q;
	srt_pkg::result_t pend_q;
	logic            pend_exp_q;
	srt_pkg::result_t out_q;
	logic            out_valid_q;

	logic            cur_valid;
	logic            out_free;
	logic            accept, adv, last_slot;
	logic            tbl_we, v_set, v_clr;
	srt_pkg::slot_t  tbl_slot;
	srt_pkg::id_t    tbl_id;
	srt_pkg::retry_t tbl_retries;
	srt_pkg::age_t   tbl_age;
	srt_pkg::cnt_t   cnt_nxt;
	logic            mid_push, pend_load, fin_push, clr_inc;
	srt_pkg::result_t pend_new, fin_res;
	srt_pkg::slot_t  new_slot;

	assign cur_valid = valid_q[slot_q];
	assign out_free  = !out_valid_q || res.ready;
	assign last_slot = (slot_q == srt_pkg::slot_t'(srt_pkg::TABLE_DEPTH - 1));
	assign new_slot  = match_found_q ? match_slot_q : free_slot_q;
	assign req.ready = (state_q == srt_pkg::ST_IDLE);

	srt_entry_alu u_alu (
		.entry_id      (id_q[slot_q]),
		.entry_retries (retries_q[slot_q]),
		.entry_age     (age_q[slot_q]),
		.key           (key_q),
		.mask          (mask_q),
		.regs          (regs),
		.res           (alu)
	);

	always_comb begin
		accept      = 1'b0;
		adv         = 1'b0;
		tbl_we      = 1'b0;
		v_set       = 1'b0;
		v_clr       = 1'b0;
		tbl_slot    = slot_q;
		tbl_id      = id_q[slot_q];
		tbl_retries = retries_q[slot_q];
		tbl_age     = alu.age_next;
		cnt_nxt     = cnt_q;
		mid_push    = 1'b0;
		pend_load   = 1'b0;
		fin_push    = 1'b0;
		clr_inc     = 1'b0;
		pend_new    = pend_q;
		fin_res     = '{kind: srt_pkg::KIND_IDLE, result_id: '0, attempt: '0,
			cleared_count: '0, outstanding: srt_pkg::outst_t'(cnt_q), last: 1'b1};

		unique case (state_q)
			srt_pkg::ST_IDLE: begin
				accept = req.valid;
			end
			srt_pkg::ST_SCAN: begin
				adv = 1'b1;
				case (cmd_q)
					srt_pkg::CMD_ACK: begin
						if (cur_valid && alu.ack_hit) begin
							v_clr   = 1'b1;
							clr_inc = 1'b1;
							cnt_nxt = cnt_q - 1'b1;
						end
					end
					srt_pkg::CMD_TICK: begin
						if (cur_valid) begin
							if (!alu.expire) begin
								tbl_we = 1'b1;
							end else if (pend_exp_q && !out_free) begin
								adv = 1'b0;     // previous expiry still waiting
							end else begin
								mid_push  = pend_exp_q;
								pend_load = 1'b1;
								if (alu.drop) begin
									v_clr    = 1'b1;
									cnt_nxt  = cnt_q - 1'b1;
									pend_new = '{kind: srt_pkg::KIND_DROP,
										result_id: id_q[slot_q],
										attempt: retries_q[slot_q], cleared_count: '0,
										outstanding: srt_pkg::outst_t'(cnt_q - 1'b1),
										last: 1'b0};
								end else begin
									tbl_we      = 1'b1;
									tbl_age     = '0;
									tbl_retries = alu.retries_next;
									pend_new    = '{kind: srt_pkg::KIND_RETX,
										result_id: id_q[slot_q],
										attempt: alu.retries_next, cleared_count: '0,
										outstanding: srt_pkg::outst_t'(cnt_q),
										last: 1'b0};
								end
							end
						end
					end
					default: ;
				endcase
			end
			srt_pkg::ST_FIN: begin
				fin_push = out_free;
				case (cmd_q)
					srt_pkg::CMD_SEND: begin
						if (match_found_q || free_found_q) begin
							tbl_we      = out_free;
							v_set       = out_free;
							tbl_slot    = new_slot;
							tbl_id      = key_q;
							tbl_retries = '0;
							tbl_age     = '0;
							if (!match_found_q) cnt_nxt = cnt_q + 1'b1;
							fin_res.kind        = srt_pkg::KIND_SENT;
							fin_res.outstanding = srt_pkg::outst_t'(cnt_nxt);
						end else begin
							fin_res.kind = srt_pkg::KIND_FULL;
						end
						fin_res.result_id = key_q;
						if (!out_free) cnt_nxt = cnt_q;
					end
					srt_pkg::CMD_ACK: begin
						if (sess_ok_q) begin
							fin_res.kind          = srt_pkg::KIND_ACKED;
							fin_res.cleared_count = cleared_q;
						end else begin
							fin_res.kind = srt_pkg::KIND_BAD_SESS;
						end
					end
					srt_pkg::CMD_TICK: begin
						if (pend_exp_q) begin
							fin_res      = pend_q;
							fin_res.last = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// valid bits: cleared by reset, the rest of the table is written before use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srt_pkg::TABLE_DEPTH; i++) valid_q[i] <= 1'b0;
		end else if (v_set) begin
			valid_q[tbl_slot] <= 1'b1;
		end else if (v_clr) begin
			valid_q[tbl_slot] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			id_q[tbl_slot]      <= tbl_id;
			retries_q[tbl_slot] <= tbl_retries;
			age_q[tbl_slot]     <= tbl_age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= srt_pkg::ST_IDLE;
			cnt_q         <= '0;
			slot_q        <= '0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			pend_exp_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (accept) begin
				slot_q        <= '0;
				match_found_q <= 1'b0;
				free_found_q  <= 1'b0;
				pend_exp_q    <= 1'b0;
				if ((srt_pkg::cmd_e'(req.cmd) == srt_pkg::CMD_NOP) ||
					((srt_pkg::cmd_e'(req.cmd) == srt_pkg::CMD_ACK) &&
					(req.ack_session != regs.session_id))) begin
					state_q <= srt_pkg::ST_FIN;
				end else begin
					state_q <= srt_pkg::ST_SCAN;
				end
			end
			if (state_q == srt_pkg::ST_SCAN && adv) begin
				if (cmd_q == srt_pkg::CMD_SEND) begin
					if (cur_valid && alu.id_eq && !match_found_q) match_found_q <= 1'b1;
					if (!cur_valid && !free_found_q) free_found_q <= 1'b1;
				end
				if (last_slot) state_q <= srt_pkg::ST_FIN;
				else slot_q <= slot_q + 1'b1;
			end
			if (pend_load) pend_exp_q <= 1'b1;
			if (fin_push) state_q <= srt_pkg::ST_IDLE;
			if (mid_push || fin_push) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	// beat payload and per-item working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= srt_pkg::cmd_e'(req.cmd);
			key_q     <= (srt_pkg::cmd_e'(req.cmd) == srt_pkg::CMD_SEND) ?
				req.packet_id : req.ack_first_id;
			mask_q    <= req.ack_mask;
			sess_ok_q <= (req.ack_session == regs.session_id);
			cleared_q <= '0;
		end
		if (clr_inc) cleared_q <= cleared_q + 1'b1;
		if (state_q == srt_pkg::ST_SCAN && adv && cmd_q == srt_pkg::CMD_SEND) begin
			if (cur_valid && alu.id_eq && !match_found_q) match_slot_q <= slot_q;
			if (!cur_valid && !free_found_q) free_slot_q <= slot_q;
		end
		if (pend_load) pend_q <= pend_new;
		if (mid_push) out_q <= pend_q;
		else if (fin_push) out_q <= fin_res;
	end

	assign res.valid         = out_valid_q;
	assign res.kind          = out_q.kind;
	assign res.result_id     = out_q.result_id;
	assign res.attempt       = out_q.attempt;
	assign res.cleared_count = out_q.cleared_count;
	assign res.outstanding   = out_q.outstanding;
	assign res.last          = out_q.last;

endmodule

>>> hw/rtl/srt_cfg_regs.sv
// Configuration register file of the retransmit tracker.
// Depends on srt_pkg and srt_cfg_if.
`timescale 1ns / 1ps

module srt_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	srt_cfg_if.sink        cfg,
	output srt_pkg::cfg_t  regs
);

	srt_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.session_id           <= srt_pkg::RST_SESSION;
			regs_q.base_timeout         <= srt_pkg::RST_BASE_TMO;
			regs_q.extended_timeout     <= srt_pkg::RST_EXT_TMO;
			regs_q.extend_after_retries <= srt_pkg::RST_EXTEND_AFTER;
			regs_q.retry_limit          <= srt_pkg::RST_RETRY_LIMIT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				srt_pkg::REG_SESSION:      regs_q.session_id <= cfg.data;
				srt_pkg::REG_BASE_TMO:     regs_q.base_timeout <= cfg.data[15:0];
				srt_pkg::REG_EXT_TMO:      regs_q.extended_timeout <= cfg.data[15:0];
				srt_pkg::REG_EXTEND_AFTER: regs_q.extend_after_retries <= cfg.data[3:0];
				srt_pkg::REG_RETRY_LIMIT:  regs_q.retry_limit <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/srt_entry_alu.sv
// Shared per-entry unit: one subtractor serves id match and ack window test,
// plus age increment and timeout compare. Depends on srt_pkg.
`timescale 1ns / 1ps

module srt_entry_alu (
	input  srt_pkg::id_t      entry_id,
	input  srt_pkg::retry_t   entry_retries,
	input  srt_pkg::age_t     entry_age,
	input  srt_pkg::id_t      key,
	input  logic [4:0]        mask,
	input  srt_pkg::cfg_t     regs,
	output srt_pkg::alu_res_t res
);

	srt_pkg::id_t  diff;
	logic [4:0]    mask_sh;
	srt_pkg::age_t tmo;

	always_comb begin
		diff    = entry_id - key;
		mask_sh = mask >> diff[2:0];
		tmo     = (entry_retries < regs.extend_after_retries) ?
			regs.base_timeout : regs.extended_timeout;

		res.id_eq        = (diff == '0);
		res.ack_hit      = (diff < 32'(srt_pkg::ACK_SPAN)) && mask_sh[0];
		res.age_next     = (entry_age == srt_pkg::AGE_MAX) ? entry_age : entry_age + 16'd1;
		res.expire       = (res.age_next >= tmo);
		res.drop         = (entry_retries >= regs.retry_limit);
		res.retries_next = entry_retries + 4'd1;
	end

endmodule

>>> tb/sv/tb_top.sv
// Testbench for the selective-repeat retransmit tracker: a directed table, then random traffic.
// Every result is checked against the shadow table or, for typed rows, the row's own result.
// Depends on srt_pkg, the three channel interfaces and the tracker top level.
`timescale 1ns / 1ps

module tb_top;
	import srt_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int SETTLE_CYCLES = TABLE_DEPTH + 6;

	typedef struct {
		cmd_e       cmd;
		id_t        pid;
		id_t        sess;
		id_t        first;
		logic [4:0] mask;
		bit         typed;
		result_t    want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	srt_in_if  req_if ();
	srt_out_if res_if ();
	srt_cfg_if cfg_if ();

	selective_ack_retransmit_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// shadow copy of the tracker
	cfg_t   regs;
	logic   slot_live    [TABLE_DEPTH];
	id_t    slot_id      [TABLE_DEPTH];
	retry_t slot_retries [TABLE_DEPTH];
	age_t   slot_age     [TABLE_DEPTH];

	result_t   awaited_results [$];
	stim_row_t stim_table [$];

	int      err_count;
	int      cycle_count;
	bit      steady;
	bit      hold_off_req;
	result_t seen_res;
	result_t want_res;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic outst_t live_count();
		int n;
		n = 0;
		for (int s = 0; s < TABLE_DEPTH; s++)
			if (slot_live[s]) n++;
		return outst_t'(n);
	endfunction

	function automatic void queue_result(kind_e k, id_t rid, retry_t att, clr_t clr);
		result_t r;
		r.kind          = k;
		r.result_id     = rid;
		r.attempt       = att;
		r.cleared_count = clr;
		r.outstanding   = live_count();
		r.last          = 1'b0;
		awaited_results = {awaited_results, r};
	endfunction

	// Runs one command on the shadow table and queues the results it yields.
	function automatic void apply_command(cmd_e c, id_t pid, id_t sess, id_t first,
			logic [4:0] mask);
		int      hit_slot;
		int      n_before;
		clr_t    hits;
		id_t     target;
		age_t    tmo;
		result_t tail;
		n_before = awaited_results.size();
		case (c)
			CMD_SEND: begin
				hit_slot = -1;
				for (int s = 0; s < TABLE_DEPTH; s++)
					if (hit_slot < 0 && slot_live[s] && slot_id[s] == pid) hit_slot = s;
				for (int s = 0; s < TABLE_DEPTH; s++)
					if (hit_slot < 0 && !slot_live[s]) hit_slot = s;
				if (hit_slot < 0) begin
					queue_result(KIND_FULL, pid, '0, '0);
				end else begin
					slot_live[hit_slot]    = 1'b1;
					slot_id[hit_slot]      = pid;
					slot_retries[hit_slot] = '0;
					slot_age[hit_slot]     = '0;
					queue_result(KIND_SENT, pid, '0, '0);
				end
			end
			CMD_ACK: begin
				if (sess != regs.session_id) begin
					queue_result(KIND_BAD_SESS, '0, '0, '0);
				end else begin
					hits = '0;
					for (int i = 0; i < ACK_SPAN; i++) begin
						if (mask[i]) begin
							target = first + 32'(i);
							for (int s = 0; s < TABLE_DEPTH; s++)
								if (slot_live[s] && slot_id[s] == target) begin
									slot_live[s] = 1'b0;
									hits++;
								end
						end
					end
					queue_result(KIND_ACKED, '0, '0, hits);
				end
			end
			CMD_TICK: begin
				for (int s = 0; s < TABLE_DEPTH; s++) begin
					if (slot_live[s]) begin
						if (slot_age[s] != AGE_MAX) slot_age[s]++;
						tmo = (slot_retries[s] < regs.extend_after_retries) ?
							regs.base_timeout : regs.extended_timeout;
						if (slot_age[s] >= tmo) begin
							if (slot_retries[s] >= regs.retry_limit) begin
								slot_live[s] = 1'b0;
								queue_result(KIND_DROP, slot_id[s], slot_retries[s], '0);
							end else begin
								slot_age[s] = '0;
								slot_retries[s]++;
								queue_result(KIND_RETX, slot_id[s], slot_retries[s], '0);
							end
						end
					end
				end
				if (awaited_results.size() == n_before) queue_result(KIND_IDLE, '0, '0, '0);
			end
			default: begin
				queue_result(KIND_IDLE, '0, '0, '0);
			end
		endcase
		tail = awaited_results.pop_back();
		tail.last = 1'b1;
		awaited_results = {awaited_results, tail};
	endfunction

	function automatic void add_row(cmd_e c, id_t pid, id_t sess, id_t first, logic [4:0] mask,
			bit typed, kind_e k, id_t rid, clr_t clr, outst_t outst);
		stim_row_t row;
		row.cmd                = c;
		row.pid                = pid;
		row.sess               = sess;
		row.first              = first;
		row.mask               = mask;
		row.typed              = typed;
		row.want.kind          = k;
		row.want.result_id     = rid;
		row.want.attempt       = '0;
		row.want.cleared_count = clr;
		row.want.outstanding   = outst;
		row.want.last          = 1'b1;
		stim_table = {stim_table, row};
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One command beat; a typed row replaces the shadow's single result with its own.
	task automatic push_cmd(cmd_e c, id_t pid, id_t sess, id_t first, logic [4:0] mask,
			bit typed, result_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.cmd          <= c;
		req_if.packet_id    <= pid;
		req_if.ack_session  <= sess;
		req_if.ack_first_id <= first;
		req_if.ack_mask     <= mask;
		@(posedge clk);
		while (req_if.ready !== 1'b1) @(posedge clk);
		apply_command(c, pid, sess, first, mask);
		if (typed) begin
			void'(awaited_results.pop_back());
			awaited_results = {awaited_results, want};
		end
	endtask

	// leaves valid high; the caller lowers it after the last write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1) @(posedge clk);
		case (idx)
			REG_SESSION:      regs.session_id           = value;
			REG_BASE_TMO:     regs.base_timeout         = value[15:0];
			REG_EXT_TMO:      regs.extended_timeout     = value[15:0];
			REG_EXTEND_AFTER: regs.extend_after_retries = value[3:0];
			REG_RETRY_LIMIT:  regs.retry_limit          = value[3:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(cfg_t c);
		// junk in the unused upper data bits must be ignored
		write_reg(REG_SESSION, c.session_id);
		write_reg(REG_BASE_TMO, {16'($urandom()), c.base_timeout});
		write_reg(REG_EXT_TMO, {16'($urandom()), c.extended_timeout});
		write_reg(REG_EXTEND_AFTER, {28'($urandom()), c.extend_after_retries});
		write_reg(REG_RETRY_LIMIT, {28'($urandom()), c.retry_limit});
		cfg_if.valid <= 1'b0;
	endtask

	task automatic settle();
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly sends and acks near id_base so that acks hit and the table fills up.
	task automatic run_traffic(int count, id_t id_base);
		int         pick;
		id_t        pid;
		id_t        sess;
		id_t        first;
		logic [4:0] mask;
		result_t    none;
		none = '0;
		for (int k = 0; k < count; k++) begin
			pick  = $urandom_range(0, 99);
			pid   = $urandom();
			sess  = $urandom();
			first = $urandom();
			mask  = 5'($urandom());
			if (pick < 40) begin
				if ($urandom_range(0, 9) != 0) pid = id_base + 32'($urandom_range(0, 23));
				push_cmd(CMD_SEND, pid, sess, first, mask, 1'b0, none);
			end else if (pick < 75) begin
				push_cmd(CMD_TICK, pid, sess, first, mask, 1'b0, none);
			end else if (pick < 94) begin
				if ($urandom_range(0, 9) != 0) sess = regs.session_id;
				first = id_base + 32'($urandom_range(0, 23)) - 32'd2;
				push_cmd(CMD_ACK, pid, sess, first, mask, 1'b0, none);
			end else begin
				push_cmd(CMD_NOP, pid, sess, first, mask, 1'b0, none);
			end
		end
		req_if.valid <= 1'b0;
	endtask

	// result-side backpressure
	initial begin
		int hold;
		int r;
		hold = 0;
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				res_if.ready <= 1'b0;
			end else if (steady) begin
				res_if.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					res_if.ready <= 1'b1;
				end else begin
					res_if.ready <= 1'b0;
					hold = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			seen_res.kind          = kind_e'(res_if.kind);
			seen_res.result_id     = res_if.result_id;
			seen_res.attempt       = res_if.attempt;
			seen_res.cleared_count = res_if.cleared_count;
			seen_res.outstanding   = res_if.outstanding;
			seen_res.last          = res_if.last;
			if (awaited_results.size() == 0) begin
				report($sformatf("unexpected result beat kind %0d id %h",
					seen_res.kind, seen_res.result_id));
			end else begin
				want_res = awaited_results.pop_front();
				if (seen_res.kind !== want_res.kind)
					report($sformatf("kind got %0d want %0d", seen_res.kind, want_res.kind));
				if (seen_res.result_id !== want_res.result_id)
					report($sformatf("result_id got %h want %h",
						seen_res.result_id, want_res.result_id));
				if (seen_res.attempt !== want_res.attempt)
					report($sformatf("attempt got %0d want %0d",
						seen_res.attempt, want_res.attempt));
				if (seen_res.cleared_count !== want_res.cleared_count)
					report($sformatf("cleared_count got %0d want %0d",
						seen_res.cleared_count, want_res.cleared_count));
				if (seen_res.outstanding !== want_res.outstanding)
					report($sformatf("outstanding got %0d want %0d",
						seen_res.outstanding, want_res.outstanding));
				if (seen_res.last !== want_res.last)
					report($sformatf("last got %0d want %0d", seen_res.last, want_res.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		cfg_t next_regs;
		id_t  id_base;
		err_count    = 0;
		cycle_count  = 0;
		steady       = 1'b0;
		hold_off_req = 1'b0;
		arst_n       = 1'b0;
		req_if.valid        = 1'b0;
		req_if.cmd          = CMD_TICK;
		req_if.packet_id    = '0;
		req_if.ack_session  = '0;
		req_if.ack_first_id = '0;
		req_if.ack_mask     = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_SESSION;
		cfg_if.data  = '0;
		regs = '{session_id: RST_SESSION, base_timeout: RST_BASE_TMO,
			extended_timeout: RST_EXT_TMO, extend_after_retries: RST_EXTEND_AFTER,
			retry_limit: RST_RETRY_LIMIT};
		for (int s = 0; s < TABLE_DEPTH; s++) begin
			slot_live[s]    = 1'b0;
			slot_id[s]      = '0;
			slot_retries[s] = '0;
			slot_age[s]     = '0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, register defaults: session 0, timeouts 200 / 500
		add_row(CMD_TICK, '0, '0, '0, 5'h00, 1'b1, KIND_IDLE, '0, 3'd0, 5'd0);
		add_row(CMD_NOP, '1, '1, '1, 5'h1F, 1'b1, KIND_IDLE, '0, 3'd0, 5'd0);
		add_row(CMD_ACK, '0, '0, '0, 5'h00, 1'b1, KIND_ACKED, '0, 3'd0, 5'd0);
		add_row(CMD_ACK, '0, '1, '0, 5'h1F, 1'b1, KIND_BAD_SESS, '0, 3'd0, 5'd0);
		add_row(CMD_SEND, '0, '0, '0, 5'h00, 1'b1, KIND_SENT, '0, 3'd0, 5'd1);
		add_row(CMD_SEND, '1, '0, '0, 5'h00, 1'b1, KIND_SENT, '1, 3'd0, 5'd2);
		// duplicate id re-arms its entry
		add_row(CMD_SEND, '1, '0, '0, 5'h00, 1'b0, KIND_SENT, '0, 3'd0, 5'd0);
		// ack window wraps from all-ones to zero
		add_row(CMD_ACK, '0, '0, '1, 5'h03, 1'b0, KIND_ACKED, '0, 3'd0, 5'd0);
		for (int k = 0; k < TABLE_DEPTH; k++)
			add_row(CMD_SEND, 32'h100 + 32'(k), '0, '0, 5'h00, 1'b1, KIND_SENT,
				32'h100 + 32'(k), 3'd0, outst_t'(k + 1));
		add_row(CMD_SEND, 32'h200, '0, '0, 5'h00, 1'b1, KIND_FULL, 32'h200, 3'd0, 5'd16);
		add_row(CMD_ACK, '0, '0, 32'h10C, 5'h1F, 1'b0, KIND_ACKED, '0, 3'd0, 5'd0);
		add_row(CMD_TICK, '0, '0, '0, 5'h00, 1'b1, KIND_IDLE, '0, 3'd0, 5'd12);
		foreach (stim_table[i])
			push_cmd(stim_table[i].cmd, stim_table[i].pid, stim_table[i].sess,
				stim_table[i].first, stim_table[i].mask, stim_table[i].typed,
				stim_table[i].want);
		req_if.valid <= 1'b0;

		for (int phase = 0; phase < 6; phase++) begin
			settle();
			id_base = $urandom();
			case (phase)
				0: next_regs = '{session_id: $urandom(), base_timeout: 16'd1,
					extended_timeout: 16'd1, extend_after_retries: 4'd0, retry_limit: 4'd0};
				// zero timeouts: every live entry expires on each tick
				1: begin
					next_regs = '{session_id: '1, base_timeout: 16'd0,
						extended_timeout: 16'd0, extend_after_retries: 4'd15,
						retry_limit: 4'd15};
					id_base = 32'hFFFF_FFF4;
				end
				2: begin
					next_regs = '{session_id: $urandom(),
						base_timeout: 16'($urandom_range(2, 5)),
						extended_timeout: 16'($urandom_range(3, 9)),
						extend_after_retries: 4'($urandom_range(1, 3)),
						retry_limit: 4'($urandom_range(2, 6))};
					hold_off_req = 1'b1;
				end
				3: next_regs = '{session_id: '0, base_timeout: 16'hFFFF,
					extended_timeout: 16'hFFFF, extend_after_retries: 4'($urandom()),
					retry_limit: 4'($urandom())};
				4: begin
					next_regs = '{session_id: $urandom(),
						base_timeout: 16'($urandom_range(1, 6)),
						extended_timeout: 16'($urandom_range(1, 6)),
						extend_after_retries: 4'($urandom()),
						retry_limit: 4'($urandom())};
					steady = 1'b1;
				end
				default: next_regs = '{session_id: $urandom(),
					base_timeout: 16'($urandom_range(6, 12)),
					extended_timeout: 16'($urandom_range(2, 4)),
					extend_after_retries: 4'd1, retry_limit: 4'd2};
			endcase
			program_regs(next_regs);
			run_traffic(75, id_base);
			steady = 1'b0;
		end

		settle();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
